// ===== hw/rtl/nmls_pkg.sv =====
// Package for the normal-mapped Lambert shader: item structs, field widths,
// register indexes and shading constants. No dependencies.
`timescale 1ns / 1ps

package nmls_pkg;

  localparam int FRAC_BITS_DEF = 15;   // fraction bits of vector components
  localparam int CMP_W         = 16;   // packed vector component
  localparam int BARY_W        = 17;   // barycentric weight, Q1.16
  localparam int BARY_FRAC     = 16;
  localparam int NRM_W         = 20;   // interpolated and rotated normal
  localparam int DEC_W         = 9;    // decoded normal-map channel, +-255

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z = 2'd2;

  localparam logic signed [CMP_W-1:0] LIGHT_X_RST = 16'sd0;
  localparam logic signed [CMP_W-1:0] LIGHT_Y_RST = 16'sd0;
  localparam logic signed [CMP_W-1:0] LIGHT_Z_RST = -16'sd32767;

  localparam logic [7:0]  CH_MAX   = 8'd255;
  localparam int          CH_SAT_Q = 65280;   // 255 * 256: quotient reaches 256
  localparam logic [8:0]  RECIP_255 = 9'd257; // 257 / 2^16 just under 1/255

  localparam int FLAG_TEXEL = 0;
  localparam int FLAG_NMAP  = 1;

  typedef struct packed {
    logic [BARY_W-1:0] bary_u;
    logic [BARY_W-1:0] bary_v;
    logic [BARY_W-1:0] bary_w;
    logic [23:0]       vertex_color;
    logic [47:0]       normal_a;
    logic [47:0]       normal_b;
    logic [47:0]       normal_c;
    logic [47:0]       tangent_vec;
    logic [47:0]       bitangent_vec;
    logic [23:0]       texel_color;
    logic [23:0]       normal_texel;
    logic [1:0]        sample_flags;
  } frag_t;

  typedef struct packed {
    logic [23:0] pixel_color;
  } pix_t;

endpackage

// ===== hw/rtl/nmls_stream_if.sv =====
// Valid/ready stream channel carrying one item of payload type T.
// Used for the fragment input and the pixel output; no dependencies.
`timescale 1ns / 1ps

interface nmls_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/nmls_delay.sv =====
// Enabled delay line of fixed depth for side data that rides along the pipe.
// No dependencies.
`timescale 1ns / 1ps

module nmls_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign d_o = pipe_q[DEPTH-1];

endmodule

// ===== hw/rtl/nmls_isqrt.sv =====
// Pipelined integer square root, one root bit per stage (RW stages).
// Exact floor(sqrt(x)). No dependencies.
`timescale 1ns / 1ps

module nmls_isqrt #(
  parameter int RW = 9
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] x_i,
  output logic [RW-1:0]   root_o
);

  logic [RW:0]     rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] x_q    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [RW:0]     rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] x_in;
    logic [RW+2:0]   part;
    logic [RW+2:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    // bring down two radicand bits, test (2R+1)^2
    assign part  = {rem_in, x_in[2*RW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (part >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (RW+1)'(part - trial) : part[RW:0];
        root_q[k] <= {root_in[RW-2:0], ge};
        x_q[k]    <= x_in << 2;
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ===== hw/rtl/nmls_div.sv =====
// Pipelined restoring divider, one quotient bit per stage (QW stages).
// Partial remainder rem_i must be below den_i. No dependencies.
`timescale 1ns / 1ps

module nmls_div #(
  parameter int DW = 9,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign low_in = low_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        quo_q[k] <= {quo_in[QW-2:0], ge};
        low_q[k] <= low_in << 1;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== hw/rtl/nmls_norm.sv =====
// Pipelined 3-vector normalize: squares, sum, square root, three dividers.
// Uses nmls_isqrt, nmls_div, nmls_delay.
`timescale 1ns / 1ps

module nmls_norm #(
  parameter int CW   = 9,
  parameter int FRAC = 15
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [CW-1:0]  vec_i [3],
  output logic signed [FRAC+1:0] vec_o [3]
);

  localparam int SW = 2 * CW;
  localparam int QW = FRAC + 1;

  logic signed [SW-1:0] sqs   [3];
  logic        [SW-1:0] sq_q  [3];
  logic signed [CW-1:0] v0_q  [3];
  logic signed [CW-1:0] v1_q  [3];
  logic        [SW-1:0] ss_q;
  logic        [CW-1:0] len;
  logic      [3*CW-1:0] vd;
  logic        [CW-1:0] mag   [3];
  logic        [QW-1:0] quo   [3];
  logic           [3:0] fl_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqs[i] = vec_i[i] * vec_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= $unsigned(sqs[i]);
        v0_q[i] <= vec_i[i];
        v1_q[i] <= v0_q[i];
      end
      ss_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  nmls_isqrt #(.RW(CW)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .x_i    (ss_q),
    .root_o (len)
  );

  nmls_delay #(.W(3*CW), .DEPTH(CW)) u_vdly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   ({v1_q[0], v1_q[1], v1_q[2]}),
    .d_o   (vd)
  );

  // |c| <= len, so |c| >> 1 is already below the divisor
  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [CW-1:0] comp;
    assign comp   = vd[3*CW-1-CW*i -: CW];
    assign mag[i] = comp[CW-1] ? (~comp + 1'b1) : comp;

    nmls_div #(.DW(CW), .QW(QW)) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (mag[i] >> 1),
      .low_i ({mag[i][0], {FRAC{1'b0}}}),
      .den_i (len),
      .quo_o (quo[i])
    );
  end

  nmls_delay #(.W(4), .DEPTH(QW)) u_fdly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   ({vd[3*CW-1], vd[2*CW-1], vd[CW-1], len == '0}),
    .d_o   (fl_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fl_d[0]) begin
        vec_o[i] = '0;
      end else if (fl_d[3-i]) begin
        vec_o[i] = -$signed({1'b0, quo[i]});
      end else begin
        vec_o[i] = $signed({1'b0, quo[i]});
      end
    end
  end

endmodule

// ===== hw/rtl/normal_mapped_lambert_shade.sv =====
// Throughput: one item per cycle while pix_o is not stalled; every stage is a
// register with one global advance enable, the two square roots and dividers
// are bit-per-stage pipes.
// Reset clears all valid bits and loads the light registers with 0, 0, -32767.
// Uses nmls_pkg, nmls_stream_if, nmls_norm, nmls_delay.
`timescale 1ns / 1ps

module normal_mapped_lambert_shade
  import nmls_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  nmls_stream_if.sink           frag_i,
  nmls_stream_if.source         pix_o
);

  localparam int F   = FRAC_BITS;
  localparam int TW  = F + 2;                      // unit vector component
  localparam int N1  = 2 + DEC_W + F + 1;          // texel normalize
  localparam int N2  = 2 + NRM_W + F + 1;          // rotated normalize
  localparam int L   = N1 + N2 + 7;
  localparam int IPW = CMP_W + BARY_W + 1;
  localparam int ISW = IPW + 2;
  localparam int PW  = NRM_W + TW;
  localparam int LW  = (NRM_W > TW) ? NRM_W : TW;
  localparam int IW  = LW + 19;
  localparam int CPW = 16 + IW - 1;
  localparam int QX  = (CPW - 2*F > 17) ? CPW - 2*F : 17;

  // light registers
  logic signed [CMP_W-1:0] lt_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q[0] <= LIGHT_X_RST;
      lt_q[1] <= LIGHT_Y_RST;
      lt_q[2] <= LIGHT_Z_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LIGHT_X: lt_q[0] <= cfg_data_i;
        REG_LIGHT_Y: lt_q[1] <= cfg_data_i;
        REG_LIGHT_Z: lt_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic         adv;
  logic [L-1:0] vld_q;

  assign adv          = !vld_q[L-1] || pix_o.ready;
  assign frag_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-2:0], frag_i.valid};
    end
  end

  // input unpack
  frag_t fr;
  assign fr = frag_i.data;

  logic signed [CMP_W-1:0] na [3], nb [3], nc [3];
  logic signed [BARY_W:0]  bu, bv, bw;
  logic signed [DEC_W-1:0] dv [3];
  logic        [15:0]      m_in [3];

  assign bu = $signed({1'b0, fr.bary_u});
  assign bv = $signed({1'b0, fr.bary_v});
  assign bw = $signed({1'b0, fr.bary_w});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      na[i] = $signed(fr.normal_a[47-16*i -: 16]);
      nb[i] = $signed(fr.normal_b[47-16*i -: 16]);
      nc[i] = $signed(fr.normal_c[47-16*i -: 16]);
      dv[i] = DEC_W'($signed({2'b00, fr.normal_texel[23-8*i -: 8], 1'b0}) - 11'sd255);
      // c*255 with no texel: the later /255 then reduces to c*I
      m_in[i] = fr.sample_flags[FLAG_TEXEL] ?
                fr.vertex_color[23-8*i -: 8] * fr.texel_color[23-8*i -: 8] :
                fr.vertex_color[23-8*i -: 8] * CH_MAX;
    end
  end

  // barycentric interpolation, two stages
  logic signed [IPW-1:0]   ip_q  [9];
  logic signed [ISW-1:0]   nsum  [3];
  logic signed [NRM_W-1:0] nrm_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nsum[i] = ip_q[3*i] + ip_q[3*i+1] + ip_q[3*i+2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ip_q[3*i]   <= na[i] * bu;
        ip_q[3*i+1] <= nb[i] * bv;
        ip_q[3*i+2] <= nc[i] * bw;
        nrm_q[i]    <= NRM_W'(nsum[i] >>> BARY_FRAC);
      end
    end
  end

  // texel normal decode and normalize
  logic signed [TW-1:0] tv [3];

  nmls_norm #(.CW(DEC_W), .FRAC(F)) u_norm_tex (
    .clk_i (clk_i),
    .en_i  (adv),
    .vec_i (dv),
    .vec_o (tv)
  );

  // side data
  logic [95:0]          tb_d;
  logic [3*NRM_W-1:0]   nrm_d1, nrm_d2;
  logic [49:0]          sd_d;

  nmls_delay #(.W(96), .DEPTH(N1)) u_tb_dly (
    .clk_i (clk_i), .en_i (adv),
    .d_i   ({fr.tangent_vec, fr.bitangent_vec}),
    .d_o   (tb_d)
  );

  nmls_delay #(.W(3*NRM_W), .DEPTH(N1-2)) u_nrm_dly1 (
    .clk_i (clk_i), .en_i (adv),
    .d_i   ({nrm_q[0], nrm_q[1], nrm_q[2]}),
    .d_o   (nrm_d1)
  );

  nmls_delay #(.W(3*NRM_W), .DEPTH(N2+2)) u_nrm_dly2 (
    .clk_i (clk_i), .en_i (adv),
    .d_i   (nrm_d1),
    .d_o   (nrm_d2)
  );

  nmls_delay #(.W(50), .DEPTH(N1+N2+2)) u_sd_dly (
    .clk_i (clk_i), .en_i (adv),
    .d_i   ({fr.sample_flags, m_in[0], m_in[1], m_in[2]}),
    .d_o   (sd_d)
  );

  // rotation by [T B N], two stages
  logic signed [CMP_W-1:0] tg [3], bt [3];
  logic signed [NRM_W-1:0] nr1 [3];
  logic signed [PW-1:0]    rp_q [9];
  logic signed [PW+1:0]    rsum [3];
  logic signed [NRM_W-1:0] r_q  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tg[i]   = $signed(tb_d[95-16*i -: 16]);
      bt[i]   = $signed(tb_d[47-16*i -: 16]);
      nr1[i]  = $signed(nrm_d1[3*NRM_W-1-NRM_W*i -: NRM_W]);
      rsum[i] = rp_q[3*i] + rp_q[3*i+1] + rp_q[3*i+2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rp_q[3*i]   <= tg[i] * tv[0];
        rp_q[3*i+1] <= bt[i] * tv[1];
        rp_q[3*i+2] <= nr1[i] * tv[2];
        r_q[i]      <= NRM_W'(rsum[i] >>> F);
      end
    end
  end

  logic signed [TW-1:0] lv [3];

  nmls_norm #(.CW(NRM_W), .FRAC(F)) u_norm_rot (
    .clk_i (clk_i),
    .en_i  (adv),
    .vec_i (r_q),
    .vec_o (lv)
  );

  // intensity, two stages
  logic signed [LW-1:0]    lit  [3];
  logic signed [CMP_W:0]   negl [3];
  logic signed [LW+16:0]   ipd_q [3];
  logic signed [IW-1:0]    inten_q;
  logic        [15:0]      m1_q [3], m2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lit[i]  = sd_d[48 + FLAG_NMAP] ? LW'(lv[i]) :
                LW'($signed(nrm_d2[3*NRM_W-1-NRM_W*i -: NRM_W]));
      negl[i] = -lt_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ipd_q[i] <= lit[i] * negl[i];
        m1_q[i]  <= sd_d[47-16*i -: 16];
        m2_q[i]  <= m1_q[i];
      end
      inten_q <= ipd_q[0] + ipd_q[1] + ipd_q[2];
    end
  end

  // color: scale, shift, divide by 255 via reciprocal and one correction
  logic             pos1_q, pos2_q;
  logic [CPW-1:0]   cp_q  [3];
  logic [QX-1:0]    qx    [3];
  logic [24:0]      em    [3];
  logic             sat_q [3];
  logic [15:0]      q16_q [3];
  logic [8:0]       e_q   [3];
  logic [16:0]      e255  [3];
  logic [16:0]      rr    [3];
  logic [7:0]       ch    [3];
  logic [23:0]      px_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i]   = QX'(cp_q[i] >> (2*F));
      em[i]   = qx[i][15:0] * RECIP_255;
      e255[i] = e_q[i] * CH_MAX;
      rr[i]   = {1'b0, q16_q[i]} - e255[i];
      if (sat_q[i]) begin
        ch[i] = CH_MAX;
      end else if (rr[i] >= 17'(CH_MAX)) begin
        ch[i] = 8'(e_q[i] + 1'b1);
      end else begin
        ch[i] = e_q[i][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos1_q <= !inten_q[IW-1] && (inten_q != '0);
      pos2_q <= pos1_q;
      for (int i = 0; i < 3; i++) begin
        cp_q[i]  <= m2_q[i] * inten_q[IW-2:0];
        sat_q[i] <= (qx[i] >= QX'(CH_SAT_Q));
        q16_q[i] <= qx[i][15:0];
        e_q[i]   <= em[i][24:16];
      end
      px_q <= pos2_q ? {ch[0], ch[1], ch[2]} : '0;
    end
  end

  assign pix_o.valid            = vld_q[L-1];
  assign pix_o.data.pixel_color = px_q;

endmodule

// ===== hw/rtl/nmls_checker.sv =====
// Port-level checks for normal_mapped_lambert_shade, attached by bind.
// Sees only the top-level handshake and output payload.
`timescale 1ns / 1ps

module nmls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] out_data_i
);

  // a stalled pixel stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("pixel changed while stalled");

  // an empty output slot never blocks fragments
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // a stalled output freezes the whole pipe, so no item may enter
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !(in_valid_i && in_ready_i))
    else $error("item accepted during output stall");

endmodule

bind normal_mapped_lambert_shade nmls_checker u_nmls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (frag_i.valid),
  .in_ready_i  (frag_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_data_i  (pix_o.data.pixel_color)
);

// ===== test/nmls_shade_checker.sv =====
// Scoreboard for the normal-mapped Lambert shader: predicts each pixel from the
// fragment and the light registers and compares it. Uses nmls_pkg, nmls_stream_if.
`timescale 1ns / 1ps

module nmls_shade_checker
  import nmls_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  nmls_stream_if                frag_ch,
  nmls_stream_if                pix_ch,
  output int                    err_cnt_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef longint vec3_t [3];

  logic signed [CMP_W-1:0] light_x, light_y, light_z;
  logic [23:0]             pix_expect_q [$];

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // components scaled to unit length, truncated toward zero
  function automatic vec3_t to_unit(vec3_t v);
    vec3_t o;
    longint len;
    len = longint'(sqrt_floor(v[0]*v[0] + v[1]*v[1] + v[2]*v[2]));
    for (int i = 0; i < 3; i++) o[i] = (len == 0) ? 0 : (v[i] * (64'sd1 << 15)) / len;
    return o;
  endfunction

  function automatic vec3_t unpack3(logic [47:0] p);
    vec3_t v;
    v[0] = $signed(p[47:32]);
    v[1] = $signed(p[31:16]);
    v[2] = $signed(p[15:0]);
    return v;
  endfunction

  function automatic logic [23:0] shade_pixel(frag_t f);
    vec3_t na, nb, nc, tg, bt, nrm, lit, dec, tn, rot, lt;
    longint inten, c, tc, ch;
    logic [23:0] pix;
    na = unpack3(f.normal_a);
    nb = unpack3(f.normal_b);
    nc = unpack3(f.normal_c);
    tg = unpack3(f.tangent_vec);
    bt = unpack3(f.bitangent_vec);
    lt[0] = light_x;
    lt[1] = light_y;
    lt[2] = light_z;
    for (int i = 0; i < 3; i++)
      nrm[i] = (na[i] * longint'(f.bary_u) + nb[i] * longint'(f.bary_v)
                + nc[i] * longint'(f.bary_w)) >>> 16;
    if (f.sample_flags[FLAG_NMAP]) begin
      for (int i = 0; i < 3; i++)
        dec[i] = 2 * longint'(f.normal_texel[23-8*i -: 8]) - 255;
      tn = to_unit(dec);
      for (int i = 0; i < 3; i++)
        rot[i] = (tg[i] * tn[0] + bt[i] * tn[1] + nrm[i] * tn[2]) >>> 15;
      lit = to_unit(rot);
    end else begin
      lit = nrm;
    end
    inten = 0;
    for (int i = 0; i < 3; i++) inten += lit[i] * (-lt[i]);
    pix = '0;
    if (inten > 0) begin
      for (int i = 0; i < 3; i++) begin
        c  = f.vertex_color[23-8*i -: 8];
        tc = f.texel_color[23-8*i -: 8];
        if (f.sample_flags[FLAG_TEXEL]) ch = (c * tc * inten) / (64'sd255 << 30);
        else ch = (c * inten) >>> 30;
        pix[23-8*i -: 8] = (ch > 255) ? 8'd255 : ch[7:0];
      end
    end
    return pix;
  endfunction

  assign pending_o = pix_expect_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x   <= LIGHT_X_RST;
      light_y   <= LIGHT_Y_RST;
      light_z   <= LIGHT_Z_RST;
      err_cnt_o <= 0;
      checked_o <= 0;
      pix_expect_q.delete();
    end else begin
      if (frag_ch.valid && frag_ch.ready) pix_expect_q.push_back(shade_pixel(frag_ch.data));
      if (pix_ch.valid && pix_ch.ready) begin
        checked_o <= checked_o + 1;
        if (pix_expect_q.size() == 0) begin
          if (err_cnt_o < 10) $display("unexpected pixel %h", pix_ch.data.pixel_color);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          if (pix_ch.data.pixel_color !== pix_expect_q[0]) begin
            if (err_cnt_o < 10)
              $display("pixel_color exp %h got %h", pix_expect_q[0], pix_ch.data.pixel_color);
            err_cnt_o <= err_cnt_o + 1;
          end
          void'(pix_expect_q.pop_front());
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LIGHT_X: light_x <= cfg_data_i;
          REG_LIGHT_Y: light_y <= cfg_data_i;
          REG_LIGHT_Z: light_z <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for normal_mapped_lambert_shade: clock, reset, light register
// writes and fragment stimulus; checking lives in nmls_shade_checker.
`timescale 1ns / 1ps

module tb_top;
  import nmls_pkg::*;

  localparam int DRAIN_CYC = 2 * FRAC_BITS_DEF + 50;
  localparam int IDLE_LIMIT = 5000;

  logic                  clk_i, rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    err_cnt, pending, checked, sent, idle_cyc, ready_hold;
  bit                    no_gaps;

  nmls_stream_if #(.T(frag_t)) frag_ch ();
  nmls_stream_if #(.T(pix_t))  pix_ch ();

  normal_mapped_lambert_shade u_top (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .frag_i(frag_ch), .pix_o(pix_ch)
  );

  nmls_shade_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .frag_ch, .pix_ch, .err_cnt_o(err_cnt), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // output stall: drawn per accepted pixel
  always @(posedge clk_i) begin
    if (pix_ch.valid && pix_ch.ready) ready_hold = no_gaps ? 0 : $urandom_range(0, 4);
    if (ready_hold > 0) begin
      pix_ch.ready <= 1'b0;
      ready_hold--;
    end else begin
      pix_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((frag_ch.valid && frag_ch.ready) || (pix_ch.valid && pix_ch.ready)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("timeout");
      $display("normal_mapped_lambert_shade: mismatch");
      $finish;
    end
  end

  task automatic write_light(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_light(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    wait (pending == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    write_light(REG_LIGHT_X, x);
    write_light(REG_LIGHT_Y, y);
    write_light(REG_LIGHT_Z, z);
  endtask

  task automatic send_frag(frag_t f);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      frag_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    frag_ch.valid <= 1'b1;
    frag_ch.data  <= f;
    do @(posedge clk_i); while (!frag_ch.ready);
    sent++;
  endtask

  function automatic logic [15:0] rand_cmp();
    logic [15:0] c;
    c = 16'($urandom());
    case ($urandom_range(0, 3))
      0: return c;
      1: return $signed(c) >>> 4;
      2: return $signed(c) >>> 1;
      default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  function automatic logic [47:0] rand_vec();
    return {rand_cmp(), rand_cmp(), rand_cmp()};
  endfunction

  function automatic frag_t rand_frag();
    frag_t f;
    int u, v;
    if ($urandom_range(0, 9) < 8) begin
      u = $urandom_range(0, 65536);
      v = $urandom_range(0, 65536 - u);
      f.bary_u = 17'(u);
      f.bary_v = 17'(v);
      f.bary_w = 17'(65536 - u - v);
    end else begin
      f.bary_u = 17'($urandom());
      f.bary_v = 17'($urandom());
      f.bary_w = 17'($urandom());
    end
    f.vertex_color  = 24'($urandom());
    f.normal_a      = rand_vec();
    f.normal_b      = rand_vec();
    f.normal_c      = rand_vec();
    f.tangent_vec   = rand_vec();
    f.bitangent_vec = rand_vec();
    f.texel_color   = 24'($urandom());
    f.normal_texel  = 24'($urandom());
    f.sample_flags  = 2'($urandom());
    return f;
  endfunction

  task automatic run_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
      send_frag(rand_frag());
    end
    frag_ch.valid <= 1'b0;
  endtask

  initial begin
    frag_t f;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    frag_ch.valid = 1'b0;
    frag_ch.data  = '0;
    pix_ch.ready  = 1'b0;
    sent = 0; idle_cyc = 0; ready_hold = 0; no_gaps = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset light points down -z; normals toward +z light up
    for (int k = 0; k < 16; k++) begin
      f = '0;
      f.bary_u = 17'd65536;
      f.vertex_color = (k[0]) ? 24'hffffff : 24'h80ff01;
      f.texel_color  = (k[1]) ? 24'hffffff : 24'h00ff7f;
      f.normal_a = (k < 12) ? {16'h0000, 16'h0000, 16'h7fff} : 48'h0;
      f.tangent_vec   = {16'h7fff, 16'h0000, 16'h0000};
      f.bitangent_vec = {16'h0000, 16'h7fff, 16'h0000};
      f.normal_texel  = (k[2]) ? 24'hffffff : 24'h000000;
      f.sample_flags  = k[1:0];
      if (k == 12) f.sample_flags = 2'b10;     // zero-length interpolated normal
      if (k == 13) f.normal_a = {16'h8000, 16'h8000, 16'h8000};
      if (k == 14) begin                       // bary_v and bary_w at max, large normals
        f.bary_v = 17'h1ffff;
        f.bary_w = 17'h1ffff;
        f.normal_a = {3{16'h7fff}};
        f.normal_b = {3{16'h7fff}};
        f.normal_c = {3{16'h7fff}};
      end
      if (k == 15) f.normal_a = {16'h0000, 16'h0000, 16'h8000};  // facing away
      send_frag(f);
    end
    frag_ch.valid <= 1'b0;
    run_random(60);

    set_light(16'h0000, 16'h0000, 16'h8000);
    run_random(80);
    set_light(16'h7fff, 16'h7fff, 16'h7fff);
    run_random(80);
    set_light(16'h8000, 16'h8000, 16'h8000);
    run_random(80);
    set_light(16'($urandom()), 16'($urandom()), 16'($urandom()));
    run_random(80);

    wait (pending == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("sent %0d fragments, checked %0d pixels over five light settings",
             sent, checked);
    if (err_cnt == 0 && pending == 0) begin
      $display("normal_mapped_lambert_shade: match");
    end else begin
      $display("%0d errors, %0d pixels outstanding", err_cnt, pending);
      $display("normal_mapped_lambert_shade: mismatch");
    end
    $finish;
  end

endmodule
